// ===== hw/rtl/rtd_code_to_temperature_top_macros.svh =====
// Assertion macros for the RTD code to temperature block.
// Both take a label, an antecedent and a consequent, sampled on clk with rst as disable.
`ifndef RTD_CODE_TO_TEMPERATURE_TOP_MACROS_SVH
`define RTD_CODE_TO_TEMPERATURE_TOP_MACROS_SVH
`ifndef SYNTH
`define RTDT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtdt same-cycle check failed");
`define RTDT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtdt next-cycle check failed");
`else
`define RTDT_ASSERT_IMPL(lbl, ante, cons)
`define RTDT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/rtdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rtdt_pkg;

  // Field and datapath widths.
  localparam int CODE_W  = 15;
  localparam int REF_W   = 20;
  localparam int NOM_W   = 18;
  localparam int N_W     = 35;
  localparam int D_W     = 33;
  localparam int TEMP_W  = 19;
  localparam int Q_W     = 30;
  localparam int LOQ_W   = 24;
  localparam int LO_W    = 20;
  localparam int QUO_W   = 20;
  localparam int ACC_W   = 41;
  localparam int ROOT_W  = 47;
  localparam int NUM_W   = 43;

  // Pipeline geometry.
  localparam int DIV_STAGES  = 30;
  localparam int HORNER_STEPS = 5;
  localparam int SQRT_STEPS  = 23;
  localparam int LAT_LOWER   = 11;
  localparam int LAT_UPPER   = 46;

  // Register reset values.
  localparam logic [REF_W-1:0] REF_RESET = 20'd68800;
  localparam logic [NOM_W-1:0] NOM_RESET = 18'd16000;

  // Register indexes.
  typedef enum logic [0:0] {
    REG_REFERENCE = 1'b0,
    REG_NOMINAL   = 1'b1
  } cfg_reg_t;

  // Output range.
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sd262143;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -19'sd65536;
  localparam logic signed [LO_W-1:0]   LO_MAX   = 20'sd262143;
  localparam logic signed [LO_W-1:0]   LO_MIN   = -20'sd65536;
  localparam logic [QUO_W-1:0]         QUO_MAX  = 20'd262143;

  // Upper branch constants.
  localparam logic [44:0] CVD_A2  = 45'd17610655648041;
  localparam logic [29:0] CVD_C   = 30'd650207196;
  localparam logic [23:0] CVD_A30 = 24'd4196505;

  // Lower branch polynomial, highest term first.
  localparam logic signed [ACC_W-1:0] HORNER_E5 = 41'sd1636704662;
  localparam logic signed [ACC_W-1:0] HORNER_COEF [HORNER_STEPS] = '{
    -41'sd3026126583,
    -41'sd5181878043,
    41'sd27765889827,
    41'sd238671332639,
    -41'sd259866996244
  };

  // Branch flags that travel with each request.
  typedef struct packed {
    logic lower;
    logic far;
  } flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rtd_code_to_temperature_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted request passes stage A, the shared divider, the branch pipelines and the output register.
// Throughput: one request per cycle; a stall on the output freezes the whole pipeline.
// The pipeline depth is set by the two bit-per-stage dividers and the bit-per-stage square root.
// Reset clears every valid bit and restores both resistance registers to their defaults.
`include "rtd_code_to_temperature_top_macros.svh"
module rtd_code_to_temperature_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [0:0]                           cfg_index,
  input  logic [rtdt_pkg::REF_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rtdt_pkg::CODE_W-1:0]          rtd_code,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rtdt_pkg::TEMP_W-1:0]   temperature
);

  logic [rtdt_pkg::REF_W-1:0] reference_resistance;
  logic [rtdt_pkg::NOM_W-1:0] nominal_resistance;
  logic [rtdt_pkg::D_W-1:0]   d;
  logic [rtdt_pkg::N_W-1:0]   d_ext;
  logic                       adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_resistance <= rtdt_pkg::REF_RESET;
      nominal_resistance   <= rtdt_pkg::NOM_RESET;
    end else if (cfg_wr_en) begin
      unique case (rtdt_pkg::cfg_reg_t'(cfg_index))
        rtdt_pkg::REG_REFERENCE: reference_resistance <= cfg_data;
        rtdt_pkg::REG_NOMINAL:   nominal_resistance   <= cfg_data[rtdt_pkg::NOM_W-1:0];
        default: ;
      endcase
    end
  end

  assign d     = {nominal_resistance, 15'b0};
  assign d_ext = {2'b0, d};

  // The whole pipeline moves when the output register is free or being taken.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage A: resistance numerator.
  logic                     a_valid;
  logic [rtdt_pkg::N_W-1:0] a_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_n <= rtdt_pkg::N_W'(rtd_code) * rtdt_pkg::N_W'(reference_resistance);
    end
  end

  // Stage B: branch choice, offset and far-range detection.
  logic                     b_lower;
  logic [rtdt_pkg::N_W-1:0] b_x;
  logic                     b_far;

  always_comb begin
    b_lower = a_n < d_ext;
    b_x     = b_lower ? a_n : a_n - d_ext;
    b_far   = !b_lower && (b_x >= {d, 2'b0});
  end

  // Shared divider: floor(x * 2^28 / d), two integer and 28 fraction bits.
  logic [rtdt_pkg::DIV_STAGES:0] div_v;
  logic [rtdt_pkg::N_W-1:0]      div_r [0:rtdt_pkg::DIV_STAGES];
  logic [rtdt_pkg::Q_W-1:0]      div_q [0:rtdt_pkg::DIV_STAGES];
  rtdt_pkg::flags_t              div_f [0:rtdt_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_v <= '0;
    end else if (adv) begin
      div_v <= {div_v[rtdt_pkg::DIV_STAGES-1:0], a_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0] <= b_x;
      div_q[0] <= '0;
      div_f[0] <= '{lower: b_lower, far: b_far};
    end
  end

  for (genvar k = 0; k < rtdt_pkg::DIV_STAGES; k++) begin : g_div
    logic [rtdt_pkg::N_W:0] rs;
    logic [rtdt_pkg::N_W:0] dv;
    logic [rtdt_pkg::N_W:0] diff;
    logic                   ge;

    always_comb begin
      rs   = (k >= 2) ? {div_r[k], 1'b0} : {1'b0, div_r[k]};
      dv   = (k == 0) ? {2'b0, d, 1'b0} : {3'b0, d};
      ge   = rs >= dv;
      diff = rs - dv;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[k+1] <= ge ? diff[rtdt_pkg::N_W-1:0] : rs[rtdt_pkg::N_W-1:0];
        div_q[k+1] <= {div_q[k][rtdt_pkg::Q_W-2:0], ge};
        div_f[k+1] <= div_f[k];
      end
    end
  end

  // Both branches run side by side on every request.
  logic [rtdt_pkg::QUO_W-1:0]        quo;
  logic signed [rtdt_pkg::LO_W-1:0]  t_lo;

  rtdt_upper u_upper (
    .clk (clk),
    .en  (adv),
    .dq  (div_q[rtdt_pkg::DIV_STAGES]),
    .quo (quo)
  );

  rtdt_horner u_horner (
    .clk  (clk),
    .en   (adv),
    .q    (div_q[rtdt_pkg::DIV_STAGES][27:4]),
    .t_lo (t_lo)
  );

  // Valid bits and flags alongside the branch pipelines.
  logic [rtdt_pkg::LAT_UPPER:1]       sv;
  rtdt_pkg::flags_t                   sf   [1:rtdt_pkg::LAT_UPPER];
  logic signed [rtdt_pkg::LO_W-1:0]   lo_d [rtdt_pkg::LAT_LOWER+1:rtdt_pkg::LAT_UPPER];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (adv) begin
      sv <= {sv[rtdt_pkg::LAT_UPPER-1:1], div_v[rtdt_pkg::DIV_STAGES]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sf[1] <= div_f[rtdt_pkg::DIV_STAGES];
      for (int k = 2; k <= rtdt_pkg::LAT_UPPER; k++) begin
        sf[k] <= sf[k-1];
      end
      lo_d[rtdt_pkg::LAT_LOWER+1] <= t_lo;
      for (int k = rtdt_pkg::LAT_LOWER + 2; k <= rtdt_pkg::LAT_UPPER; k++) begin
        lo_d[k] <= lo_d[k-1];
      end
    end
  end

  // Branch selection and saturation.
  logic signed [rtdt_pkg::TEMP_W-1:0] t_sel;
  logic signed [rtdt_pkg::LO_W-1:0]   lo_last;

  assign lo_last = lo_d[rtdt_pkg::LAT_UPPER];

  always_comb begin
    if (sf[rtdt_pkg::LAT_UPPER].lower) begin
      if (lo_last < rtdt_pkg::LO_MIN) begin
        t_sel = rtdt_pkg::TEMP_MIN;
      end else if (lo_last > rtdt_pkg::LO_MAX) begin
        t_sel = rtdt_pkg::TEMP_MAX;
      end else begin
        t_sel = lo_last[rtdt_pkg::TEMP_W-1:0];
      end
    end else if (sf[rtdt_pkg::LAT_UPPER].far || (quo > rtdt_pkg::QUO_MAX)) begin
      t_sel = rtdt_pkg::TEMP_MAX;
    end else begin
      t_sel = $signed(quo[rtdt_pkg::TEMP_W-1:0]);
    end
  end

  // Output register.
  logic out_lower;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sv[rtdt_pkg::LAT_UPPER];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      temperature <= t_sel;
      out_lower   <= sf[rtdt_pkg::LAT_UPPER].lower;
    end
  end

  // Checks on the datapath and the stall logic.
  `RTDT_ASSERT_IMPL(a_div_rem_bound, div_v[rtdt_pkg::DIV_STAGES] && !div_f[rtdt_pkg::DIV_STAGES].far, div_r[rtdt_pkg::DIV_STAGES] < d_ext)
  `RTDT_ASSERT_NEXT(a_stall_freeze, !adv, $stable(sv[rtdt_pkg::LAT_UPPER]))
  `RTDT_ASSERT_IMPL(a_upper_nonneg, out_valid && !out_lower, !temperature[rtdt_pkg::TEMP_W-1])

endmodule
`default_nettype wire

// ===== hw/rtl/rtdt_horner.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtdt_horner (
  input  logic                                clk,
  input  logic                                en,
  input  logic [rtdt_pkg::LOQ_W-1:0]          q,
  output logic signed [rtdt_pkg::LO_W-1:0]    t_lo
);

  logic signed [rtdt_pkg::ACC_W-1:0] acc  [1:rtdt_pkg::HORNER_STEPS];
  logic [rtdt_pkg::LOQ_W-1:0]        qd   [1:rtdt_pkg::HORNER_STEPS-1];
  logic [63:0]                       prod [0:rtdt_pkg::HORNER_STEPS-1];
  logic                              pneg [0:rtdt_pkg::HORNER_STEPS-1];
  logic [rtdt_pkg::LOQ_W-1:0]        qa   [0:rtdt_pkg::HORNER_STEPS-2];

  // Each Horner step is a multiply stage followed by a round and add stage.
  for (genvar i = 0; i < rtdt_pkg::HORNER_STEPS; i++) begin : g_step
    logic signed [rtdt_pkg::ACC_W-1:0] src;
    logic [rtdt_pkg::LOQ_W-1:0]        qsrc;
    logic [rtdt_pkg::ACC_W-1:0]        mag;
    logic [63:0]                       pr;
    logic signed [rtdt_pkg::ACC_W-1:0] ps;
    logic signed [rtdt_pkg::ACC_W-1:0] sum;

    if (i == 0) begin : g_first
      assign src  = rtdt_pkg::HORNER_E5;
      assign qsrc = q;
    end else begin : g_rest
      assign src  = acc[i];
      assign qsrc = qd[i];
    end

    assign mag = src[rtdt_pkg::ACC_W-1] ? rtdt_pkg::ACC_W'(-src) : rtdt_pkg::ACC_W'(src);

    always_ff @(posedge clk) begin
      if (en) begin
        prod[i] <= 64'(mag[rtdt_pkg::ACC_W-2:0]) * 64'(qsrc);
        pneg[i] <= src[rtdt_pkg::ACC_W-1];
      end
    end

    // Round the product to the accumulator scale, half away from zero.
    always_comb begin
      pr  = prod[i] + (64'd1 << 23);
      ps  = $signed({1'b0, pr[63:24]});
      sum = rtdt_pkg::HORNER_COEF[i] + (pneg[i] ? -ps : ps);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[i+1] <= sum;
      end
    end

    // The ratio travels alongside for every step but the last.
    if (i < rtdt_pkg::HORNER_STEPS - 1) begin : g_qfwd
      always_ff @(posedge clk) begin
        if (en) begin
          qa[i]   <= qsrc;
          qd[i+1] <= qa[i];
        end
      end
    end
  end

  // Final scaling to 1/256 degree, half away from zero.
  logic [rtdt_pkg::ACC_W-1:0] fmag;
  logic [rtdt_pkg::ACC_W-1:0] fsum;
  logic signed [rtdt_pkg::LO_W-1:0] fpos;

  always_comb begin
    fmag = acc[rtdt_pkg::HORNER_STEPS][rtdt_pkg::ACC_W-1] ?
           rtdt_pkg::ACC_W'(-acc[rtdt_pkg::HORNER_STEPS]) :
           rtdt_pkg::ACC_W'(acc[rtdt_pkg::HORNER_STEPS]);
    fsum = fmag + (41'd1 << 21);
    fpos = $signed({1'b0, fsum[40:22]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_lo <= acc[rtdt_pkg::HORNER_STEPS][rtdt_pkg::ACC_W-1] ? -fpos : fpos;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rtdt_upper.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtdt_upper (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rtdt_pkg::Q_W-1:0]     dq,
  output logic [rtdt_pkg::QUO_W-1:0]   quo
);

  logic [59:0]                  prod;
  logic [rtdt_pkg::Q_W-1:0]     dq0;
  logic [rtdt_pkg::ROOT_W-1:0]  sq_v  [0:rtdt_pkg::SQRT_STEPS-1];
  logic [rtdt_pkg::ROOT_W-1:0]  sq_r  [0:rtdt_pkg::SQRT_STEPS];
  logic [rtdt_pkg::Q_W-1:0]     sq_dq [0:rtdt_pkg::SQRT_STEPS];
  logic [rtdt_pkg::NUM_W-1:0]   d2_r   [0:rtdt_pkg::QUO_W-1];
  logic [23:0]                  d2_den [0:rtdt_pkg::QUO_W-1];
  logic [rtdt_pkg::QUO_W-1:0]   d2_q   [0:rtdt_pkg::QUO_W];
  logic [23:0]                  den_c;

  // Slope term of the discriminant, then the discriminant itself.
  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= 60'(dq) * 60'(rtdt_pkg::CVD_C);
      dq0      <= dq;
      sq_v[0]  <= rtdt_pkg::ROOT_W'(rtdt_pkg::CVD_A2) - rtdt_pkg::ROOT_W'(prod[59:16]);
      sq_r[0]  <= '0;
      sq_dq[0] <= dq0;
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar s = 0; s < rtdt_pkg::SQRT_STEPS; s++) begin : g_sqrt
    logic [rtdt_pkg::ROOT_W-1:0] bitv;
    logic [rtdt_pkg::ROOT_W-1:0] tb;
    logic                        ge;

    always_comb begin
      bitv = rtdt_pkg::ROOT_W'(1) << (44 - 2 * s);
      tb   = sq_r[s] + bitv;
      ge   = sq_v[s] >= tb;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[s+1]  <= ge ? (sq_r[s] >> 1) + bitv : sq_r[s] >> 1;
        sq_dq[s+1] <= sq_dq[s];
      end
    end

    if (s < rtdt_pkg::SQRT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          sq_v[s+1] <= ge ? sq_v[s] - tb : sq_v[s];
        end
      end
    end
  end

  // Denominator and rounded numerator of the final quotient.
  assign den_c = rtdt_pkg::CVD_A30 + sq_r[rtdt_pkg::SQRT_STEPS][23:0];

  always_ff @(posedge clk) begin
    if (en) begin
      d2_den[0] <= den_c;
      d2_r[0]   <= rtdt_pkg::NUM_W'({sq_dq[rtdt_pkg::SQRT_STEPS], 11'b0}) +
                   rtdt_pkg::NUM_W'(den_c >> 1);
      d2_q[0]   <= '0;
    end
  end

  // Restoring division, one quotient bit per stage from the top.
  for (genvar k = 0; k < rtdt_pkg::QUO_W; k++) begin : g_div
    logic [rtdt_pkg::NUM_W-1:0] dsh;
    logic                       ge;

    always_comb begin
      dsh = rtdt_pkg::NUM_W'(d2_den[k]) << (rtdt_pkg::QUO_W - 1 - k);
      ge  = d2_r[k] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d2_q[k+1] <= {d2_q[k][rtdt_pkg::QUO_W-2:0], ge};
      end
    end

    if (k < rtdt_pkg::QUO_W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          d2_r[k+1]   <= ge ? d2_r[k] - dsh : d2_r[k];
          d2_den[k+1] <= d2_den[k];
        end
      end
    end
  end

  assign quo = d2_q[rtdt_pkg::QUO_W];

endmodule
`default_nettype wire

// ===== sim/rtd_code_to_temperature_top_test.sv =====
`timescale 1ns / 1ps
module rtd_code_to_temperature_top_test;

  localparam int LATENCY = 79;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [0:0] cfg_index;
  logic [rtdt_pkg::REF_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [rtdt_pkg::CODE_W-1:0] rtd_code;
  logic out_valid;
  logic out_ready;
  logic signed [rtdt_pkg::TEMP_W-1:0] temperature;

  rtd_code_to_temperature_top dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .rtd_code(rtd_code), .out_valid(out_valid), .out_ready(out_ready),
    .temperature(temperature)
  );

  // Local copy of the resistance registers used for prediction.
  logic [rtdt_pkg::REF_W-1:0] ref_ohms;
  logic [rtdt_pkg::NOM_W-1:0] nom_ohms;

  logic [rtdt_pkg::CODE_W-1:0] code_queue[$];
  logic signed [rtdt_pkg::TEMP_W-1:0] temp_expected[$];
  int mismatches;
  int results_seen;
  int requests_sent;
  int idle_cycles;
  bit calm;

  // Integer square root, rounded down.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Product scaled down by 2^24, rounded half away from zero.
  function automatic longint scale_q24(input longint a, input longint q);
    longint mag;
    longint p;
    mag = (a >= 0) ? a : -a;
    p = (mag * q + (64'sd1 <<< 23)) >>> 24;
    return (a >= 0) ? p : -p;
  endfunction

  // Temperature predicted from a code and the current resistance registers.
  function automatic logic signed [rtdt_pkg::TEMP_W-1:0] cvd_temperature(
      input logic [rtdt_pkg::CODE_W-1:0] code);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] diff;
    logic [63:0] dq;
    logic [63:0] disc;
    logic [63:0] den;
    logic [63:0] q;
    longint t;
    longint acc;
    longint mag;
    n = 64'(code) * 64'(ref_ohms);
    d = 64'(nom_ohms) << 15;
    if (n >= d) begin
      diff = n - d;
      if (diff >= 4 * d) begin
        t = 262143;
      end else begin
        dq = (diff << 28) / d;
        disc = 64'(rtdt_pkg::CVD_A2) - ((dq * 64'(rtdt_pkg::CVD_C)) >> 16);
        den = 64'(rtdt_pkg::CVD_A30) + floor_sqrt(disc);
        t = longint'((2048 * dq + den / 2) / den);
      end
    end else begin
      q = (n << 24) / d;
      acc = 1636704662;
      acc = -64'sd3026126583 + scale_q24(acc, q);
      acc = -64'sd5181878043 + scale_q24(acc, q);
      acc = 64'sd27765889827 + scale_q24(acc, q);
      acc = 64'sd238671332639 + scale_q24(acc, q);
      acc = -64'sd259866996244 + scale_q24(acc, q);
      mag = (acc >= 0) ? acc : -acc;
      mag = (mag + (64'sd1 <<< 21)) >>> 22;
      t = (acc >= 0) ? mag : -mag;
    end
    if (t > 262143) t = 262143;
    if (t < -65536) t = -65536;
    return t[rtdt_pkg::TEMP_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: error: %s", $time, what);
    mismatches++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Request driver: bursts of idling except in the calm tail of the run.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      rtd_code <= '0;
      idle_cycles = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready) begin
        temp_expected.push_back(cvd_temperature(rtd_code));
        requests_sent++;
      end
      if (idle_cycles > 0) begin
        idle_cycles--;
        in_valid <= 0;
      end else if (code_queue.size() > 0) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          idle_cycles = $urandom_range(1, 10) - 1;
          in_valid <= 0;
        end else begin
          rtd_code <= code_queue.pop_front();
          in_valid <= 1;
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Result monitor with random back-pressure.
  int stall_cycles;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      stall_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (temp_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected temperature %0d", temperature));
        end else if (temperature !== temp_expected[0]) begin
          report_mismatch($sformatf("temperature %0d, predicted %0d",
                                    temperature, temp_expected[0]));
          void'(temp_expected.pop_front());
        end else begin
          void'(temp_expected.pop_front());
        end
      end
      if (stall_cycles > 0) begin
        stall_cycles--;
        out_ready <= 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_cycles = $urandom_range(1, 10) - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // Watchdog on cycles with no accepted request or result.
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_register(input rtdt_pkg::cfg_reg_t idx,
                                input logic [rtdt_pkg::REF_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 0;
    if (idx == rtdt_pkg::REG_REFERENCE) ref_ohms = value;
    else nom_ohms = value[rtdt_pkg::NOM_W-1:0];
  endtask

  task automatic drain_pipeline;
    while (code_queue.size() > 0 || in_valid || temp_expected.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic queue_random(input int count);
    logic [rtdt_pkg::CODE_W-1:0] c;
    longint centre;
    for (int i = 0; i < count; i++) begin
      centre = (longint'(nom_ohms) * 32768) / (ref_ohms == 0 ? 1 : longint'(ref_ohms));
      case ($urandom_range(0, 3))
        0: c = rtdt_pkg::CODE_W'($urandom_range(0, 32767));
        1: c = rtdt_pkg::CODE_W'(centre + longint'($urandom_range(0, 64)) - 32);
        2: c = rtdt_pkg::CODE_W'($urandom_range(0, 255));
        default: c = rtdt_pkg::CODE_W'(32767 - $urandom_range(0, 255));
      endcase
      code_queue.push_back(c);
    end
  endtask

  // Resistance settings per phase: reference and nominal.
  int phase_ref[6] = '{68800, 1048575, 16, 6880, 1048575, 300000};
  int phase_nom[6] = '{16000, 262143, 16, 1600, 0, 16000};

  initial begin
    rst = 1;
    cfg_wr_en = 0;
    cfg_index = rtdt_pkg::REG_REFERENCE;
    cfg_data = '0;
    in_valid = 0;
    rtd_code = '0;
    out_ready = 0;
    calm = 0;
    mismatches = 0;
    results_seen = 0;
    requests_sent = 0;
    ref_ohms = rtdt_pkg::REF_RESET;
    nom_ohms = rtdt_pkg::NOM_RESET;
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed codes at reset values: extremes and zero degrees.
    code_queue.push_back(15'd0);
    code_queue.push_back(15'd32767);
    code_queue.push_back(15'd1);
    code_queue.push_back(15'd7620);
    code_queue.push_back(15'd7621);
    code_queue.push_back(15'd7622);
    code_queue.push_back(15'd16384);
    code_queue.push_back(15'd21845);
    code_queue.push_back(15'd2000);
    code_queue.push_back(15'h5555);
    code_queue.push_back(15'h2AAA);
    drain_pipeline();

    for (int p = 0; p < 6; p++) begin
      write_register(rtdt_pkg::REG_REFERENCE, rtdt_pkg::REF_W'(phase_ref[p]));
      write_register(rtdt_pkg::REG_NOMINAL, rtdt_pkg::REF_W'(phase_nom[p]));
      code_queue.push_back(15'd0);
      code_queue.push_back(15'd32767);
      if (p == 5) calm = 1;
      queue_random(p == 0 ? 500 : 160);
      drain_pipeline();
    end

    $display("Ran %0d conversions over six resistance settings, %0d results checked.",
             requests_sent, results_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
